// ----- rtl/const_accel_speed_profile_core_defines.svh -----
// assertion macros shared by the speed profile rtl
`ifndef CONST_ACCEL_SPEED_PROFILE_CORE_DEFINES_SVH
`define CONST_ACCEL_SPEED_PROFILE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define CASP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("casp same-cycle check failed");

// next-cycle implication, sampled on clock, off during reset
`define CASP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("casp next-cycle check failed");

`endif

// ----- rtl/casp_pkg.sv -----
// types and constants of the constant acceleration speed profile core
package casp_pkg;

   localparam int SPEED_W  = 16;
   localparam int ACC_W    = 13;
   localparam int CNT_IN_W = 7;
   localparam int PL_W     = 8;
   localparam int DATA_W   = 56;
   localparam int PROD_W   = ACC_W + PL_W;
   localparam int K_SHIFT  = 9;
   localparam int K_W      = PROD_W + K_SHIFT;
   localparam int VSQ_W    = 2 * SPEED_W;
   localparam int RT_W     = 17;
   localparam int SQ_W     = 2 * RT_W;
   localparam int RAD_W    = SQ_W + 1;
   localparam int ITER_W   = 5;
   localparam int DIV_STEPS  = K_W;
   localparam int SQRT_STEPS = RT_W;
   localparam logic [PL_W-1:0] PATH_LENGTH_RESET = 8'd15;

   typedef struct packed {
      logic load_req;
      logic mul;
      logic div_step;
      logic prep;
      logic sqrt_step;
      logic emit;
   } casp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic last_pt;
      logic out_free;
   } casp_sts_type;

endpackage

// ----- rtl/casp_dp.sv -----
// datapath: request hold, step divider, square root unit, clamp and result register
`include "const_accel_speed_profile_core_defines.svh"

module casp_dp import casp_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  casp_cmd_type        cmd,
   output casp_sts_type        sts,
   input  logic [SPEED_W-1:0]  init_speed,
   input  logic [SPEED_W-1:0]  target_speed,
   input  logic [ACC_W-1:0]    acceleration,
   input  logic [CNT_IN_W-1:0] point_count,
   input  logic                csr_wr_en,
   input  logic [PL_W-1:0]     csr_wr_data,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [SPEED_W-1:0]  rsp_speed,
   output logic                rsp_last
);

   localparam int IDX_W = $clog2(MAX_POINTS);

   logic [PL_W-1:0]     path_length_ff, path_length_in;
   logic [CNT_IN_W-1:0] held_count_ff, held_count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                out_valid_ff, out_valid_in;
   logic [SPEED_W-1:0]  held_start_ff, held_start_in;
   logic [SPEED_W-1:0]  held_end_ff, held_end_in;
   logic [ACC_W-1:0]    held_accel_ff, held_accel_in;
   logic [VSQ_W-1:0]    v0sq_ff, v0sq_in;
   logic [IDX_W-1:0]    div_rem_ff, div_rem_in;
   logic [K_W-1:0]      div_quo_ff, div_quo_in;
   logic [K_W-1:0]      q_ff, q_in;
   logic [IDX_W-1:0]    r_ff, r_in;
   logic [SQ_W-1:0]     sq_x_ff, sq_x_in;
   logic [RT_W-1:0]     root_ff, root_in;
   logic [RT_W:0]       srem_ff, srem_in;
   logic [SPEED_W-1:0]  out_speed_ff, out_speed_in;
   logic                out_last_ff, out_last_in;

   logic [CNT_IN_W-1:0] cnt_m1;
   logic [IDX_W-1:0]    d;
   logic [ACC_W-1:0]    mag;
   logic [PROD_W-1:0]   prod;
   logic [IDX_W:0]      div_sh, div_sub;
   logic [IDX_W:0]      frac_sum, frac_sub;
   logic [RAD_W-1:0]    rad_pos, rad_neg, rad;
   logic [RT_W+2:0]     sr_sh, sr_trial, sr_diff;
   logic                acc_pos, acc_neg;
   logic [RT_W-1:0]     vend_x, v_clamp;
   logic [SPEED_W-1:0]  v_sat;

   assign cnt_m1  = held_count_ff - CNT_IN_W'(1);
   assign d       = cnt_m1[IDX_W-1:0];
   assign acc_neg = held_accel_ff[ACC_W-1];
   assign acc_pos = !held_accel_ff[ACC_W-1] && (held_accel_ff != '0);
   assign mag     = acc_neg ? (~held_accel_ff + ACC_W'(1)) : held_accel_ff;
   assign prod    = PROD_W'(mag) * PROD_W'(path_length_ff);

   assign div_sh   = {div_rem_ff, div_quo_ff[K_W-1]};
   assign div_sub  = div_sh - {1'b0, d};
   assign frac_sum = {1'b0, r_ff} + {1'b0, div_rem_ff};
   assign frac_sub = frac_sum - {1'b0, d};

   assign rad_pos = {{(RAD_W-VSQ_W){1'b0}}, v0sq_ff} + {{(RAD_W-K_W){1'b0}}, q_ff};
   assign rad_neg = {{(RAD_W-VSQ_W){1'b0}}, v0sq_ff} - {{(RAD_W-K_W){1'b0}}, q_ff};
   assign rad     = acc_neg ? rad_neg : rad_pos;

   assign sr_sh    = {srem_ff, sq_x_ff[SQ_W-1 -: 2]};
   assign sr_trial = {1'b0, root_ff, 2'b01};
   assign sr_diff  = sr_sh - sr_trial;

   assign vend_x = {1'b0, held_end_ff};

   always_comb begin
      v_clamp = root_ff;
      if (acc_pos && (root_ff > vend_x)) begin
         v_clamp = vend_x;
      end else if (acc_neg && (root_ff < vend_x)) begin
         v_clamp = vend_x;
      end
      v_sat = v_clamp[RT_W-1] ? {SPEED_W{1'b1}} : v_clamp[SPEED_W-1:0];
   end

   always_comb begin
      path_length_in = csr_wr_en ? csr_wr_data : path_length_ff;
      held_count_in  = held_count_ff;
      idx_in         = idx_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      held_start_in  = held_start_ff;
      held_end_in    = held_end_ff;
      held_accel_in  = held_accel_ff;
      v0sq_in        = v0sq_ff;
      div_rem_in     = div_rem_ff;
      div_quo_in     = div_quo_ff;
      q_in           = q_ff;
      r_in           = r_ff;
      sq_x_in        = sq_x_ff;
      root_in        = root_ff;
      srem_in        = srem_ff;
      out_speed_in   = out_speed_ff;
      out_last_in    = out_last_ff;

      if (cmd.load_req) begin
         held_start_in = init_speed;
         held_end_in   = target_speed;
         held_accel_in = acceleration;
         held_count_in = (point_count > CNT_IN_W'(MAX_POINTS)) ?
                         CNT_IN_W'(MAX_POINTS) : point_count;
         idx_in        = '0;
         q_in          = '0;
         r_in          = '0;
      end

      if (cmd.mul) begin
         v0sq_in    = VSQ_W'(held_start_ff) * VSQ_W'(held_start_ff);
         div_quo_in = {prod, {K_SHIFT{1'b0}}};
         div_rem_in = '0;
      end

      if (cmd.div_step) begin
         if (div_sh >= {1'b0, d}) begin
            div_rem_in = div_sub[IDX_W-1:0];
            div_quo_in = {div_quo_ff[K_W-2:0], 1'b1};
         end else begin
            div_rem_in = div_sh[IDX_W-1:0];
            div_quo_in = {div_quo_ff[K_W-2:0], 1'b0};
         end
      end

      if (cmd.prep) begin
         sq_x_in = rad[RAD_W-1] ? '0 : rad[SQ_W-1:0];
         root_in = '0;
         srem_in = '0;
      end

      if (cmd.sqrt_step) begin
         sq_x_in = {sq_x_ff[SQ_W-3:0], 2'b00};
         if (sr_sh >= sr_trial) begin
            srem_in = sr_diff[RT_W:0];
            root_in = {root_ff[RT_W-2:0], 1'b1};
         end else begin
            srem_in = sr_sh[RT_W:0];
            root_in = {root_ff[RT_W-2:0], 1'b0};
         end
      end

      if (cmd.emit) begin
         out_speed_in = v_sat;
         out_last_in  = sts.last_pt;
         out_valid_in = 1'b1;
         idx_in       = idx_ff + IDX_W'(1);
         if (frac_sum >= {1'b0, d}) begin
            r_in = frac_sub[IDX_W-1:0];
            q_in = q_ff + div_quo_ff + K_W'(1);
         end else begin
            r_in = frac_sum[IDX_W-1:0];
            q_in = q_ff + div_quo_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         path_length_ff <= PATH_LENGTH_RESET;
         held_count_ff  <= '0;
         idx_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         path_length_ff <= path_length_in;
         held_count_ff  <= held_count_in;
         idx_ff         <= idx_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_start_ff <= held_start_in;
      held_end_ff   <= held_end_in;
      held_accel_ff <= held_accel_in;
      v0sq_ff       <= v0sq_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      q_ff          <= q_in;
      r_ff          <= r_in;
      sq_x_ff       <= sq_x_in;
      root_ff       <= root_in;
      srem_ff       <= srem_in;
      out_speed_ff  <= out_speed_in;
      out_last_ff   <= out_last_in;
   end

   assign sts.count_zero = (held_count_ff == '0);
   assign sts.last_pt    = ({{(CNT_IN_W-IDX_W){1'b0}}, idx_ff} == cnt_m1);
   assign sts.out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_speed  = out_speed_ff;
   assign rsp_last   = out_last_ff;

   // step remainder never reaches the divisor
   `CASP_ASSERT_SAME(a_frac_below_div, held_count_ff > CNT_IN_W'(1), r_ff < d)

endmodule

// ----- rtl/casp_ctrl.sv -----
// controller: request accept, divide and root sequencing, point emission
`include "const_accel_speed_profile_core_defines.svh"

module casp_ctrl import casp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  casp_sts_type sts,
   output casp_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_PREP = 3'd3;
   localparam logic [2:0] ST_SQRT = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              accept;
   logic              sqrt_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign sqrt_last  = (iter_ff == ITER_W'(SQRT_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            iter_in = '0;
            if (sts.count_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(DIV_STEPS - 1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            iter_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            iter_in       = iter_ff + ITER_W'(1);
            if (sqrt_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.last_pt ? ST_IDLE : ST_PREP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   `CASP_ASSERT_NEXT(a_accept_to_mul, accept, state_ff == ST_MUL)
   `CASP_ASSERT_NEXT(a_last_to_idle, cmd.emit && sts.last_pt, state_ff == ST_IDLE)
   `CASP_ASSERT_NEXT(a_root_done, cmd.sqrt_step && sqrt_last, state_ff == ST_EMIT)

endmodule

// ----- rtl/const_accel_speed_profile_core.sv -----
// Top level of the constant acceleration speed profile core.
// Per request: accept, then multiply and a serial divide of the step term, unless the point
// count is zero, which returns to idle with no points; then per point a setup step, the shared
// square root unit and an emit step, which waits while the result side stalls. A new request
// is taken once the last point is registered. Synchronous reset clears control state,
// sets path_length to 15.
module const_accel_speed_profile_core import casp_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // initial speed, target speed, acceleration, point_count
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [SPEED_W-1:0] rsp_tdata,  // speed
   output logic              rsp_tlast,
   input  logic              csr_wr_en,
   input  logic [PL_W-1:0]   csr_wr_data
);

   casp_cmd_type cmd;
   casp_sts_type sts;

   casp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   casp_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .init_speed   (req_tdata[15:0]),
      .target_speed (req_tdata[31:16]),
      .acceleration (req_tdata[44:32]),
      .point_count  (req_tdata[51:45]),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_speed    (rsp_tdata),
      .rsp_last     (rsp_tlast)
   );

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench of the constant acceleration speed profile core
module tb_top import casp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_POINTS      = 64;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 100;
   localparam int ITEMS_PER_PHASE = 46;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      logic [CNT_IN_W-1:0]     point_count;
      logic signed [ACC_W-1:0] acceleration;
      logic [SPEED_W-1:0]      target_speed;
      logic [SPEED_W-1:0]      init_speed;
   } profile_request_type;

   typedef struct {
      logic [SPEED_W-1:0] speed;
      logic               last_point;
   } profile_point_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [DATA_W-1:0]  req_tdata = '0;   // initial speed, target speed, acceleration, point_count
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [SPEED_W-1:0] rsp_tdata;         // speed
   logic               rsp_tlast;
   logic               csr_wr_en = 1'b0;
   logic [PL_W-1:0]    csr_wr_data = '0;

   logic [PL_W-1:0]   path_length = PATH_LENGTH_RESET;
   profile_point_type expected_points[$];
   profile_point_type due_point;
   int                mismatch_count = 0;
   int                sender_idle_pct = 0;
   int                receiver_stall_pct = 0;
   int                hold_off_left = 0;

   const_accel_speed_profile_core #(
      .MAX_POINTS(MAX_POINTS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic profile_request_type make_request(int init_speed, int target_speed,
                                                        int accel, int count);
      profile_request_type r;
      r.init_speed   = SPEED_W'(init_speed);
      r.target_speed = SPEED_W'(target_speed);
      r.acceleration = ACC_W'(accel);
      r.point_count  = CNT_IN_W'(count);
      return r;
   endfunction

   // v = sqrt(v0^2 + 2*256*a*L*i/(n-1)), clamped to the target speed in the direction of a
   function automatic logic [SPEED_W-1:0] profile_speed(profile_request_type r,
                                                        int unsigned idx,
                                                        int unsigned points);
      longint          acc_val;
      longint          radicand;
      longint unsigned acc_mag;
      longint unsigned step_q;
      longint unsigned root;
      longint unsigned trial;
      acc_val  = longint'(r.acceleration);
      acc_mag  = (acc_val < 0) ? -acc_val : acc_val;
      radicand = longint'(r.init_speed) * longint'(r.init_speed);
      if (points > 1) begin
         step_q = (acc_mag * 2 * path_length * idx * 256) / (points - 1);
         radicand = (acc_val < 0) ? radicand - longint'(step_q) : radicand + longint'(step_q);
      end
      if (radicand < 0) radicand = 0;
      root = 0;
      for (int b = 20; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= unsigned'(radicand)) root = trial;
      end
      if (acc_val > 0 && root > r.target_speed) root = r.target_speed;
      else if (acc_val < 0 && root < r.target_speed) root = r.target_speed;
      if (root > 64'hFFFF) root = 64'hFFFF;
      return root[SPEED_W-1:0];
   endfunction

   function automatic profile_request_type random_request();
      int unsigned pick_start, pick_end, pick_acc, pick_count;
      int          v_init, v_target, accel, count;
      pick_start = $urandom_range(99);
      pick_end   = $urandom_range(99);
      pick_acc   = $urandom_range(99);
      pick_count = $urandom_range(99);
      v_init   = (pick_start < 8)  ? 'hFFFF :
                 (pick_start < 16) ? 0 :
                 (pick_start < 40) ? int'($urandom_range(1023)) : int'($urandom_range(65535));
      v_target = (pick_end < 8)  ? 'hFFFF :
                 (pick_end < 16) ? 0 :
                 (pick_end < 50) ? v_init + int'($urandom_range(1024)) - 512 :
                                   int'($urandom_range(65535));
      accel    = (pick_acc < 8)  ? 0 :
                 (pick_acc < 14) ? 2560 :
                 (pick_acc < 20) ? -2560 : int'($urandom_range(5120)) - 2560;
      count    = (pick_count < 3)  ? 0 :
                 (pick_count < 6)  ? int'($urandom_range(127, 65)) :
                 (pick_count < 12) ? int'($urandom_range(64, 17)) :
                                     int'($urandom_range(16, 1));
      return make_request(v_init, v_target, accel, count);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   task automatic send_request(input profile_request_type r);
      int unsigned       points;
      profile_point_type pt;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(r);
      do @(posedge clock); while (!req_tready);
      points = (r.point_count > MAX_POINTS) ? MAX_POINTS : r.point_count;
      for (int unsigned i = 0; i < points; i++) begin
         pt.speed        = profile_speed(r, i, points);
         pt.last_point   = (i + 1 == points);
         expected_points = {expected_points, pt};
      end
   endtask

   // a run of zero points leaves nothing to wait for, hence the extra pause
   task automatic set_path_length(input logic [PL_W-1:0] value);
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      path_length = value;
   endtask

   task automatic test_directed_corners();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_request(make_request('h0000, 'h0000, 0, 1));
      send_request(make_request('hFFFF, 'hFFFF, 2560, 64));
      send_request(make_request('hFFFF, 'h0000, -2560, 64));
      send_request(make_request('h0100, 'h0000, -2560, 8));
      send_request(make_request('h0100, 'h0080, -2560, 8));
      send_request(make_request('h0200, 'h0400, 2560, 16));
      send_request(make_request('h1234, 'hFFFF, 0, 5));
      send_request(make_request('h1234, 'h0000, 0, 5));
      send_request(make_request('h0500, 'h0300, 300, 1));
      send_request(make_request('h0500, 'h0800, -300, 1));
      send_request(make_request('h4000, 'h8000, 100, 0));
      send_request(make_request('h4000, 'h8000, 100, 127));
      send_request(make_request('h4000, 'hFFFF, 100, 65));
      send_request(make_request('h0A00, 'hFFFF, 1, 2));
      send_request(make_request('h0A00, 'h0000, -1, 2));
      send_request(make_request('hAAAA, 'h5555, 'h0555, 3));
      send_request(make_request('h5555, 'hAAAA, -1366, 33));
      send_request(make_request('h0000, 'hFFFF, 2560, 64));
      send_request(make_request('h0000, 'hFFFF, 'h0AAA, 7));
   endtask

   task automatic test_path_length_extremes();
      logic [PL_W-1:0] lengths[3] = '{8'd0, 8'd1, 8'd255};
      foreach (lengths[k]) begin
         set_path_length(lengths[k]);
         send_request(make_request('h0100, 'hFFFF, 2560, 10));
         send_request(make_request('h8000, 'h0000, -2560, 10));
         send_request(make_request('h1000, 'h1000, int'($urandom_range(5120)) - 2560, 1));
      end
   endtask

   task automatic test_random_traffic(input logic [PL_W-1:0] length, input int idle_pct,
                                      input int stall_pct);
      set_path_length(length);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (ITEMS_PER_PHASE) send_request(random_request());
   endtask

   // output held off long enough that the core backs up and stalls its input
   task automatic test_output_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_left      = HOLD_OFF_CYCLES;
      repeat (6)
         send_request(make_request($urandom, $urandom, int'($urandom_range(5120)) - 2560,
                                   $urandom_range(8, 2)));
   endtask

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_points.size() == 0) begin
            report_mismatch($sformatf("speed %h with no point expected", rsp_tdata));
         end else begin
            due_point = expected_points.pop_front();
            if (rsp_tdata !== due_point.speed)
               report_mismatch($sformatf("speed %h, expected %h", rsp_tdata, due_point.speed));
            if (rsp_tlast !== due_point.last_point)
               report_mismatch($sformatf("tlast %b, expected %b", rsp_tlast,
                                         due_point.last_point));
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_path_length_extremes();
      test_random_traffic(PL_W'($urandom_range(255, 1)), 0, 0);
      test_random_traffic(8'd255, 76, 0);
      test_random_traffic(8'd1, 0, 76);
      test_random_traffic(PL_W'($urandom_range(254, 2)), 27, 27);
      test_output_backpressure();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_points.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ----- const_accel_speed_profile_core.f -----
+incdir+rtl
rtl/casp_pkg.sv
rtl/casp_dp.sv
rtl/casp_ctrl.sv
rtl/const_accel_speed_profile_core.sv
test/tb_top.sv
